@@ rtl/core/kpc_pkg.sv @@
`default_nettype none
package kpc_pkg;

   localparam int PT_N       = 1024;
   localparam int PT_AW      = $clog2(PT_N);
   localparam int CL_N       = 16;
   localparam int CL_AW      = $clog2(CL_N);
   localparam int CW         = 16;
   localparam int PT_W       = 4 * CW;
   localparam int CNT_W      = PT_AW + 1;
   localparam int K_W        = CL_AW + 1;
   localparam int SUM_W      = CW + PT_AW + 1;
   localparam int SQ_W       = 2 * CW;
   localparam int DIST_W     = SQ_W + 2;
   localparam int DIV_CW     = $clog2(SUM_W);
   localparam int ROUND_W    = 8;
   localparam int LBL_W      = 5;
   localparam int IN_DATA_W  = 80;
   localparam int OUT_DATA_W = 80;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_LABEL = 2'd1;
   localparam logic [1:0] ACT_CENT  = 2'd2;

   localparam logic [1:0] RK_DONE  = 2'd0;
   localparam logic [1:0] RK_LABEL = 2'd1;
   localparam logic [1:0] RK_CENT  = 2'd2;

   localparam logic CSR_NUM_CLUSTERS = 1'b0;
   localparam logic CSR_ITER_LIMIT   = 1'b1;

   localparam logic [K_W-1:0]     NC_RESET = K_W'(8);
   localparam logic [ROUND_W-1:0] IT_RESET = ROUND_W'(10);

   typedef struct packed {
      logic               pt_we;
      logic [PT_AW-1:0]   pt_addr;
      logic               lbl_we;
      logic [PT_AW-1:0]   lbl_addr;
      logic               latch_point;
      logic               cent_clear;
      logic               cent_init_we;
      logic               cent_upd_we;
      logic [CL_AW-1:0]   j;
      logic [1:0]         c;
      logic               mul;
      logic               acc;
      logic               cmp;
      logic               sum_clear;
      logic               sum_add;
      logic               div_init;
      logic               div_upd;
      logic [CNT_W-1:0]   n;
      logic [K_W-1:0]     k;
      logic               rsp_done;
      logic               rsp_label;
      logic               rsp_cent;
      logic               label_unset;
      logic               cent_oor;
      logic [ROUND_W-1:0] rounds;
   } kpc_cmd_type;

   typedef struct packed {
      logic             div_done;
      logic [PT_AW-1:0] quo;
   } kpc_sts_type;

endpackage
`default_nettype wire

@@ rtl/core/kpc_ram.sv @@
`default_nettype none
module kpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule
`default_nettype wire

@@ rtl/core/kpc_divider.sv @@
`default_nettype none
module kpc_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [kpc_pkg::SUM_W-1:0] dividend,
   input  wire logic [kpc_pkg::CNT_W-1:0] divisor,
   output logic                           done,
   output logic      [kpc_pkg::SUM_W-1:0] quotient
);
   import kpc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvsr_ff, dvsr_in;
   logic [CNT_W:0]    trial;
   logic              ge;

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CW'(SUM_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial - {1'b0, dvsr_ff} : trial;
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/core/kpc_datapath.sv @@
`default_nettype none
module kpc_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire kpc_pkg::kpc_cmd_type            cmd,
   output kpc_pkg::kpc_sts_type                 sts,
   input  wire logic [kpc_pkg::PT_W-1:0]        req_point,
   output logic      [1:0]                      rsp_kind,
   output logic      [kpc_pkg::ROUND_W-1:0]     rsp_rounds,
   output logic      [kpc_pkg::LBL_W-1:0]       rsp_label,
   output logic      [kpc_pkg::PT_W-1:0]        rsp_cent
);
   import kpc_pkg::*;

   localparam int JN_W = CL_AW + CNT_W;

   logic [PT_W-1:0]   pt_rdata;
   logic [LBL_W-1:0]  lbl_rdata;
   logic [PT_W-1:0]   point_ff;
   logic [PT_W-1:0]   cent_ff [CL_N];
   logic [PT_W-1:0]   cent_row;
   logic [CW-1:0]     pt_c, cent_c;
   logic signed [CW:0] diff;
   logic [CW:0]       absd;
   logic [SQ_W-1:0]   sq_c, sq_ff;
   logic [DIST_W-1:0] dist_ff, best_ff;
   logic [CL_AW-1:0]  best_j_ff;
   logic signed [SUM_W-1:0] sum_ff [CL_N][4];
   logic [CNT_W-1:0]  count_ff [CL_N];
   logic [CL_AW-1:0]  sidx;
   logic [SUM_W-1:0]  s_sel, s_mag;
   logic              neg_ff;
   logic [JN_W-1:0]   jn;
   logic              div_start, div_done;
   logic [SUM_W-1:0]  div_dividend, quot, qs;
   logic [CNT_W-1:0]  div_divisor;
   logic [1:0]        kind_ff;
   logic [ROUND_W-1:0] rounds_ff;
   logic [LBL_W-1:0]  label_ff;
   logic [PT_W-1:0]   rcent_ff;

   kpc_ram #(.WIDTH(PT_W), .DEPTH(PT_N)) u_point_ram (
      .clock (clock),
      .we    (cmd.pt_we),
      .addr  (cmd.pt_addr),
      .wdata (req_point),
      .rdata (pt_rdata)
   );

   kpc_ram #(.WIDTH(LBL_W), .DEPTH(PT_N)) u_label_ram (
      .clock (clock),
      .we    (cmd.lbl_we),
      .addr  (cmd.lbl_addr),
      .wdata (LBL_W'(best_j_ff)),
      .rdata (lbl_rdata)
   );

   assign cent_row = cent_ff[cmd.j];
   assign pt_c     = point_ff[cmd.c*CW +: CW];
   assign cent_c   = cent_row[cmd.c*CW +: CW];
   assign diff     = $signed({pt_c[CW-1], pt_c}) - $signed({cent_c[CW-1], cent_c});
   assign absd     = diff[CW] ? (CW+1)'(-diff) : diff;
   assign sq_c     = absd[CW-1:0] * absd[CW-1:0];

   // Sums and counts share one index: the new label while accumulating,
   // the cluster under update otherwise.
   assign sidx  = cmd.sum_add ? best_j_ff : cmd.j;
   assign s_sel = sum_ff[sidx][cmd.c];
   assign s_mag = s_sel[SUM_W-1] ? -s_sel : s_sel;
   assign jn    = JN_W'(cmd.j) * JN_W'(cmd.n);

   assign div_start    = cmd.div_init | cmd.div_upd;
   assign div_dividend = cmd.div_init ? SUM_W'(jn) : s_mag;
   assign div_divisor  = cmd.div_init ? CNT_W'(cmd.k) : count_ff[sidx];

   kpc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   assign qs = neg_ff ? -quot : quot;

   always_ff @(posedge clock) begin
      if (cmd.latch_point) begin
         point_ff <= pt_rdata;
      end
      if (cmd.mul) begin
         sq_ff <= sq_c;
      end
      if (cmd.acc) begin
         dist_ff <= ((cmd.c == 2'd0) ? '0 : dist_ff) + DIST_W'(sq_ff);
      end
      if (cmd.cmp && (cmd.j == '0 || dist_ff < best_ff)) begin
         best_ff   <= dist_ff;
         best_j_ff <= cmd.j;
      end
      if (div_start) begin
         neg_ff <= cmd.div_upd & s_sel[SUM_W-1];
      end
      if (cmd.sum_clear) begin
         for (int q = 0; q < CL_N; q++) begin
            for (int r = 0; r < 4; r++) begin
               sum_ff[q][r] <= '0;
            end
            count_ff[q] <= '0;
         end
      end else if (cmd.sum_add) begin
         for (int r = 0; r < 4; r++) begin
            sum_ff[sidx][r] <= sum_ff[sidx][r]
               + {{(SUM_W-CW){point_ff[r*CW+CW-1]}}, point_ff[r*CW +: CW]};
         end
         count_ff[sidx] <= count_ff[sidx] + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < CL_N; q++) begin
            cent_ff[q] <= '0;
         end
      end else if (cmd.cent_clear) begin
         for (int q = 0; q < CL_N; q++) begin
            cent_ff[q] <= '0;
         end
      end else if (cmd.cent_init_we) begin
         cent_ff[cmd.j] <= pt_rdata;
      end else if (cmd.cent_upd_we) begin
         cent_ff[cmd.j][cmd.c*CW +: CW] <= (count_ff[sidx] == '0) ? '0 : qs[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_done) begin
         kind_ff   <= RK_DONE;
         rounds_ff <= cmd.rounds;
         label_ff  <= '0;
         rcent_ff  <= '0;
      end else if (cmd.rsp_label) begin
         kind_ff   <= RK_LABEL;
         rounds_ff <= '0;
         label_ff  <= cmd.label_unset ? '1 : lbl_rdata;
         rcent_ff  <= '0;
      end else if (cmd.rsp_cent) begin
         kind_ff   <= RK_CENT;
         rounds_ff <= '0;
         label_ff  <= '0;
         rcent_ff  <= cmd.cent_oor ? '0 : cent_row;
      end
   end

   assign sts.div_done = div_done;
   assign sts.quo      = quot[PT_AW-1:0];
   assign rsp_kind     = kind_ff;
   assign rsp_rounds   = rounds_ff;
   assign rsp_label    = label_ff;
   assign rsp_cent     = rcent_ff;

endmodule
`default_nettype wire

@@ rtl/core/kpc_control.sv @@
`default_nettype none
module kpc_control (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [1:0]                req_action,
   input  wire logic                      req_last,
   input  wire logic [kpc_pkg::PT_AW-1:0] req_index,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_index,
   input  wire logic [7:0]                csr_data,
   input  wire kpc_pkg::kpc_sts_type      sts,
   output kpc_pkg::kpc_cmd_type           cmd
);
   import kpc_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_LBL       = 5'd1;
   localparam logic [4:0] S_RSP       = 5'd2;
   localparam logic [4:0] S_INIT_CLR  = 5'd3;
   localparam logic [4:0] S_INIT_DIV  = 5'd4;
   localparam logic [4:0] S_INIT_WAIT = 5'd5;
   localparam logic [4:0] S_INIT_WR   = 5'd6;
   localparam logic [4:0] S_RND       = 5'd7;
   localparam logic [4:0] S_A_RD      = 5'd8;
   localparam logic [4:0] S_A_LAT     = 5'd9;
   localparam logic [4:0] S_A_MUL     = 5'd10;
   localparam logic [4:0] S_A_ACC     = 5'd11;
   localparam logic [4:0] S_A_CMP     = 5'd12;
   localparam logic [4:0] S_A_SUM     = 5'd13;
   localparam logic [4:0] S_U_DIV     = 5'd14;
   localparam logic [4:0] S_U_WAIT    = 5'd15;
   localparam logic [4:0] S_DONE      = 5'd16;

   logic [4:0]         state_ff, state_in;
   logic [PT_AW-1:0]   i_ff, i_in;
   logic [CL_AW-1:0]   j_ff, j_in;
   logic [1:0]         c_ff, c_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic               set_done_ff, set_done_in;
   logic               lbl_valid_ff, lbl_valid_in;
   logic               unset_ff, unset_in;
   logic [K_W-1:0]     nc_ff;
   logic [ROUND_W-1:0] iter_ff;
   logic               accept;
   logic [CNT_W-1:0]   n_base;
   logic               last_j, last_i;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RSP);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & req_tready;
   assign n_base     = set_done_ff ? '0 : n_ff;
   assign last_j     = ({1'b0, j_ff} == k_ff - K_W'(1));
   assign last_i     = ({1'b0, i_ff} == n_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      c_in         = c_ff;
      round_in     = round_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      set_done_in  = set_done_ff;
      lbl_valid_in = lbl_valid_ff;
      unset_in     = unset_ff;
      cmd          = '0;
      cmd.j        = j_ff;
      cmd.c        = c_ff;
      cmd.n        = n_ff;
      cmd.k        = k_ff;
      cmd.rounds   = iter_ff;
      cmd.pt_addr  = i_ff;
      cmd.lbl_addr = i_ff;
      cmd.label_unset = unset_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.lbl_addr = req_index;
            cmd.j        = req_index[CL_AW-1:0];
            cmd.pt_addr  = n_base[PT_AW-1:0];
            if (accept) begin
               case (req_action)
                  ACT_LOAD: begin
                     // A load after a finished run opens a new point set.
                     if (set_done_ff) begin
                        set_done_in  = 1'b0;
                        lbl_valid_in = 1'b0;
                     end
                     n_in = n_base;
                     if (n_base < CNT_W'(PT_N)) begin
                        cmd.pt_we = 1'b1;
                        n_in      = n_base + CNT_W'(1);
                     end
                     if (req_last) begin
                        if (nc_ff == '0) begin
                           k_in = K_W'(1);
                        end else if (nc_ff > K_W'(CL_N)) begin
                           k_in = K_W'(CL_N);
                        end else begin
                           k_in = nc_ff;
                        end
                        state_in = S_INIT_CLR;
                     end
                  end
                  ACT_LABEL: begin
                     unset_in = !lbl_valid_ff || ({1'b0, req_index} >= n_ff);
                     state_in = S_LBL;
                  end
                  ACT_CENT: begin
                     cmd.rsp_cent = 1'b1;
                     cmd.cent_oor = (req_index[PT_AW-1:CL_AW] != '0);
                     state_in     = S_RSP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LBL: begin
            cmd.rsp_label = 1'b1;
            state_in      = S_RSP;
         end
         S_RSP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         S_INIT_CLR: begin
            cmd.cent_clear = 1'b1;
            j_in           = '0;
            round_in       = '0;
            state_in       = S_INIT_DIV;
         end
         S_INIT_DIV: begin
            cmd.div_init = 1'b1;
            state_in     = S_INIT_WAIT;
         end
         S_INIT_WAIT: begin
            cmd.pt_addr = sts.quo;
            if (sts.div_done) begin
               state_in = S_INIT_WR;
            end
         end
         S_INIT_WR: begin
            cmd.cent_init_we = 1'b1;
            if (last_j) begin
               state_in = (iter_ff == '0) ? S_DONE : S_RND;
            end else begin
               j_in     = j_ff + CL_AW'(1);
               state_in = S_INIT_DIV;
            end
         end
         S_RND: begin
            cmd.sum_clear = 1'b1;
            i_in          = '0;
            state_in      = S_A_RD;
         end
         S_A_RD: begin
            state_in = S_A_LAT;
         end
         S_A_LAT: begin
            cmd.latch_point = 1'b1;
            j_in            = '0;
            c_in            = '0;
            state_in        = S_A_MUL;
         end
         S_A_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_A_ACC;
         end
         S_A_ACC: begin
            cmd.acc = 1'b1;
            c_in    = c_ff + 2'd1;
            state_in = (c_ff == 2'd3) ? S_A_CMP : S_A_MUL;
         end
         S_A_CMP: begin
            cmd.cmp = 1'b1;
            if (last_j) begin
               state_in = S_A_SUM;
            end else begin
               j_in     = j_ff + CL_AW'(1);
               state_in = S_A_MUL;
            end
         end
         S_A_SUM: begin
            cmd.sum_add  = 1'b1;
            cmd.lbl_we   = 1'b1;
            lbl_valid_in = 1'b1;
            if (last_i) begin
               j_in     = '0;
               c_in     = '0;
               state_in = S_U_DIV;
            end else begin
               i_in     = i_ff + PT_AW'(1);
               state_in = S_A_RD;
            end
         end
         S_U_DIV: begin
            cmd.div_upd = 1'b1;
            state_in    = S_U_WAIT;
         end
         S_U_WAIT: begin
            if (sts.div_done) begin
               cmd.cent_upd_we = 1'b1;
               c_in            = c_ff + 2'd1;
               state_in        = S_U_DIV;
               if (c_ff == 2'd3) begin
                  j_in = j_ff + CL_AW'(1);
                  if (last_j) begin
                     round_in = round_ff + ROUND_W'(1);
                     state_in = (round_ff + ROUND_W'(1) == iter_ff) ? S_DONE : S_RND;
                  end
               end
            end
         end
         S_DONE: begin
            cmd.rsp_done = 1'b1;
            set_done_in  = 1'b1;
            state_in     = S_RSP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         k_ff         <= K_W'(1);
         set_done_ff  <= 1'b0;
         lbl_valid_ff <= 1'b0;
         nc_ff        <= NC_RESET;
         iter_ff      <= IT_RESET;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         set_done_ff  <= set_done_in;
         lbl_valid_ff <= lbl_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_CLUSTERS: nc_ff   <= csr_data[K_W-1:0];
               CSR_ITER_LIMIT:   iter_ff <= csr_data[ROUND_W-1:0];
               default: begin
               end
            endcase
         end
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      c_ff     <= c_in;
      round_ff <= round_in;
      unset_ff <= unset_in;
   end

   a_point_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_RD) |-> ({1'b0, i_ff} < n_ff))
      else $error("point index beyond loaded set");

   a_cluster_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_MUL) |-> ({1'b0, j_ff} < k_ff))
      else $error("cluster index beyond cluster count");

   a_k_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT_DIV) |-> (k_ff != '0 && k_ff <= K_W'(CL_N)))
      else $error("cluster count out of range");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_done_marks_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (set_done_ff && rsp_tvalid))
      else $error("finished run not recorded");

endmodule
`default_nettype wire

@@ rtl/core/kmeans_point_pair_clustering.sv @@
// Loads up to 1024 points (two 2-D points each, signed 16-bit coordinates with
// 4 fraction bits) through req with tuser = 0; the transfer with tlast set runs
// Lloyd k-means with num_clusters (held to 1..16) clusters for exactly
// iteration_limit rounds and then returns one "done" response. tuser = 1 reads
// a point label and tuser = 2 reads a centroid, each answered by one response.
// A label read first reads the label memory, a centroid read answers from the
// centroid registers, and both wait for rsp_tready. A run seeds the centroids
// with one serial divide per cluster plus a point memory read, then each round
// assigns the points, set by one squarer used once per coordinate, per point and
// per cluster, and updates the centroids through the one serial divider.
// Requests are not taken while a run is in progress.
`default_nettype none
module kmeans_point_pair_clustering (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // index[9:0], first_x[25:10], first_y[41:26], second_x[57:42],
   // second_y[73:58], zeros above
   input  wire logic [kpc_pkg::IN_DATA_W-1:0]       req_tdata,
   // action[1:0]
   input  wire logic [1:0]                          req_tuser,
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rounds_run[7:0], cluster_label[12:8], centroid_first_x[28:13],
   // centroid_first_y[44:29], centroid_second_x[60:45],
   // centroid_second_y[76:61], zeros above
   output logic      [kpc_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   // result_kind[1:0]
   output logic      [1:0]                          rsp_tuser,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_index,
   input  wire logic [7:0]                          csr_data
);
   import kpc_pkg::*;

   kpc_cmd_type        cmd;
   kpc_sts_type        sts;
   logic [ROUND_W-1:0] rsp_rounds;
   logic [LBL_W-1:0]   rsp_label;
   logic [PT_W-1:0]    rsp_cent;

   kpc_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_last   (req_tlast),
      .req_index  (req_tdata[PT_AW-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .sts        (sts),
      .cmd        (cmd)
   );

   kpc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_point  (req_tdata[PT_AW +: PT_W]),
      .rsp_kind   (rsp_tuser),
      .rsp_rounds (rsp_rounds),
      .rsp_label  (rsp_label),
      .rsp_cent   (rsp_cent)
   );

   assign rsp_tdata = {{(OUT_DATA_W-ROUND_W-LBL_W-PT_W){1'b0}}, rsp_cent, rsp_label, rsp_rounds};

endmodule
`default_nettype wire
